// ===== rtl/core/lbp_pkg.sv =====
// Shared types and constants for the local binary pattern code image block.
package lbp_pkg;

    // Fixed widths of the channel payloads and configuration registers.
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register reset values and the smallest meaningful image dimension.
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam int                  MIN_DIM      = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Control flags that travel with a pixel from the read stage to the window.
    typedef struct packed {
        logic emit;
        logic frame_end;
    } stage_info_t;

endpackage

// ===== rtl/core/lbp_if.sv =====
// Handshake channel interfaces for pixel items and code items.
interface lbp_pix_if;
    logic                      valid;
    logic                      ready;
    logic [lbp_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_code_if;
    logic                       valid;
    logic                       ready;
    logic [lbp_pkg::CODE_W-1:0] code;
    logic                       frame_end;

    modport source (output valid, output code, output frame_end, input ready);
    modport sink   (input valid, input code, input frame_end, output ready);
endinterface

// ===== rtl/core/lbp_linebuf.sv =====
// Two-row line buffer: one entry per column holds the pixels of the two previous rows.
module lbp_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int PW    = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [PW-1:0] wr_top,
    input  logic [PW-1:0] wr_mid,
    output logic [PW-1:0] rd_top,
    output logic [PW-1:0] rd_mid
);

    logic [2*PW-1:0] mem [DEPTH];
    logic [2*PW-1:0] rd_data_reg;

    // Write port: the older row in the upper half, the newer row in the lower half.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_top, wr_mid};
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_top = rd_data_reg[2*PW-1:PW];
    assign rd_mid = rd_data_reg[PW-1:0];

endmodule

// ===== rtl/core/lbp_window.sv =====
// Two-column window registers, neighbour compare and the output register.
module lbp_window #(
    parameter int PW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  lbp_pkg::stage_info_t info,
    input  logic [PW-1:0]        top,
    input  logic [PW-1:0]        mid,
    input  logic [PW-1:0]        bot,
    output logic                 out_free,
    lbp_code_if.source           code_out
);

    // Index 0..2: left column (top, middle, bottom); 3..5: centre column.
    logic [PW-1:0]                 win_reg  [6];
    logic [PW-1:0]                 win_next [6];
    logic                          valid_reg;
    logic                          valid_next;
    logic [lbp_pkg::CODE_W-1:0]    code_reg;
    logic [lbp_pkg::CODE_W-1:0]    code_next;
    logic                          end_reg;
    logic                          end_next;
    logic [lbp_pkg::CODE_W-1:0]    code_calc;
    logic [PW-1:0]                 ctr;

    // Each bit is set when its neighbour is at least the centre pixel.
    assign ctr = win_reg[4];
    always_comb
    begin
        code_calc[0] = (win_reg[0] >= ctr);
        code_calc[1] = (win_reg[3] >= ctr);
        code_calc[2] = (top >= ctr);
        code_calc[3] = (mid >= ctr);
        code_calc[4] = (bot >= ctr);
        code_calc[5] = (win_reg[5] >= ctr);
        code_calc[6] = (win_reg[2] >= ctr);
        code_calc[7] = (win_reg[1] >= ctr);
    end

    // Window shifts one column for every item that leaves the read stage.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (adv)
        begin
            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = top;
            win_next[4] = mid;
            win_next[5] = bot;
        end
    end

    // Output register: loaded by an emitting item, cleared when taken.
    assign out_free = !valid_reg || code_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        end_next   = end_reg;
        if (code_out.ready)
        begin
            valid_next = 1'b0;
        end
        if (adv && info.emit)
        begin
            valid_next = 1'b1;
            code_next  = code_calc;
            end_next   = info.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        end_reg  <= end_next;
    end

    assign code_out.valid     = valid_reg;
    assign code_out.code      = code_reg;
    assign code_out.frame_end = end_reg;

endmodule

// ===== rtl/core/lbp_code_image_top.sv =====
// Top level of the streaming 3x3 local binary pattern code image block.
//
// Pixels enter on pix_in in raster order, one item per valid/ready handshake.
// For every pixel off the image border one 8-bit code leaves on code_out once the pixel
// that completes its window (its bottom-right neighbour) has gone through the read stage
// into the output register; frame_end marks the code of the last interior pixel.  Border
// pixels produce no code item.  While code_out does not stall, one pixel is accepted
// every cycle: the line buffer is read at acceptance and written back when the pixel
// leaves the read stage, one read and one write port, so the rate is one item per clock.
// When code_out stalls, one finished code waits in the output register while
// the read stage still takes a pixel; pix_in.ready drops only once both hold
// an item.  The APB port sets the image width (address 0) and height
// (address 4); a write restarts the frame at row 0, column 0 and must be made
// while the block is idle.  Reset clears the counters, window and output
// valid and loads width 640 and height 480; the line buffer is not cleared,
// as every entry is rewritten in each frame before it is used.
module lbp_code_image_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lbp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lbp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lbp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    lbp_pix_if.sink                            pix_in,
    lbp_code_if.source                         code_out
);

    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int PW = (PIXEL_BITS < lbp_pkg::PIX_W) ? PIXEL_BITS : lbp_pkg::PIX_W;
    localparam int HW = lbp_pkg::HEIGHT_W;

    logic [lbp_pkg::WIDTH_W-1:0] width_reg;
    logic [lbp_pkg::WIDTH_W-1:0] width_next;
    logic [HW-1:0]               height_reg;
    logic [HW-1:0]               height_next;
    logic [AW-1:0]               col_reg;
    logic [AW-1:0]               col_next;
    logic [HW-1:0]               row_reg;
    logic [HW-1:0]               row_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [PW-1:0]               s1_pix_reg;
    logic [AW-1:0]               s1_col_reg;
    lbp_pkg::stage_info_t        s1_info_reg;
    lbp_pkg::stage_info_t        s1_info_next;

    logic                        cfg_wr;
    logic                        accept;
    logic                        adv;
    logic                        out_free;
    logic [EW-1:0]               eff_w;
    logic [HW-1:0]               eff_h;
    logic                        last_col;
    logic                        last_row;
    logic [PW-1:0]               rd_top;
    logic [PW-1:0]               rd_mid;

    // APB register access; every access completes in its access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                lbp_pkg::REG_WIDTH:  width_next  = pwdata[lbp_pkg::WIDTH_W-1:0];
                lbp_pkg::REG_HEIGHT: height_next = pwdata[HW-1:0];
                default:             width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lbp_pkg::REG_WIDTH:
                prdata = {{(lbp_pkg::APB_DATA_W - lbp_pkg::WIDTH_W){1'b0}}, width_reg};
            lbp_pkg::REG_HEIGHT:
                prdata = {{(lbp_pkg::APB_DATA_W - HW){1'b0}}, height_reg};
            default:
                prdata = '0;
        endcase
    end

    // Effective frame size: width clamped to 3..MAX_WIDTH, height to at least 3.
    always_comb
    begin
        if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else if (width_reg < lbp_pkg::WIDTH_W'(lbp_pkg::MIN_DIM))
        begin
            eff_w = EW'(lbp_pkg::MIN_DIM);
        end
        else
        begin
            eff_w = EW'(width_reg);
        end
        eff_h = (height_reg < HW'(lbp_pkg::MIN_DIM)) ? HW'(lbp_pkg::MIN_DIM) : height_reg;
    end

    // Handshake: the read stage empties whenever the output register can take its result.
    assign adv          = s1_valid_reg && out_free;
    assign pix_in.ready = !s1_valid_reg || out_free;
    assign accept       = pix_in.valid && pix_in.ready;

    // Raster position of the next pixel.
    assign last_col = (EW'(col_reg) == (eff_w - EW'(1)));
    assign last_row = (row_reg == (eff_h - HW'(1)));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + HW'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    // Read stage: a code is due once two rows and two columns have gone by.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        s1_info_next.emit      = (row_reg >= HW'(2)) && (col_reg >= AW'(2));
        s1_info_next.frame_end = last_row && last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= lbp_pkg::WIDTH_RESET;
            height_reg   <= lbp_pkg::HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix_in.pixel[PW-1:0];
            s1_col_reg  <= col_reg;
            s1_info_reg <= s1_info_next;
        end
    end

    // Line buffer: read at acceptance, rows shifted up when the item moves on.
    lbp_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .PW    (PW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (adv),
        .wr_addr (s1_col_reg),
        .wr_top  (rd_mid),
        .wr_mid  (s1_pix_reg),
        .rd_top  (rd_top),
        .rd_mid  (rd_mid)
    );

    // Window, compare and output register.
    lbp_window #(
        .PW (PW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .info     (s1_info_reg),
        .top      (rd_top),
        .mid      (rd_mid),
        .bot      (s1_pix_reg),
        .out_free (out_free),
        .code_out (code_out)
    );

    // An emitting item that leaves the read stage shows up on the output.
    a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_info_reg.emit |=> code_out.valid)
        else $error("emitting item did not reach the output register");

    // Pixels in the first two columns never produce a code.
    a_border_col: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (col_reg < AW'(2)) |=> !s1_info_reg.emit)
        else $error("border column pixel marked to emit");

    // The column counter stays inside the effective width.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(col_reg) < eff_w)
        else $error("column counter beyond image width");

    // With both stages full and the output stalled, no pixel is taken.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && code_out.valid && !code_out.ready |-> !pix_in.ready)
        else $error("pixel accepted while both stages are blocked");

    // A frame end flag only leaves together with a valid code.
    a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_info_reg.frame_end |-> s1_info_reg.emit)
        else $error("frame end on a border pixel");

endmodule
